// File: sv/gld_pkg.sv
// Shared constants and helpers for the GIF LZW decoder.
// No dependencies; imported by the decoder top level.
package gld_pkg;

  localparam int unsigned MaxCodes    = 4096;
  localparam int unsigned MaxCodeBits = 12;
  localparam int unsigned TableAw     = 12;
  localparam int unsigned CntW        = TableAw + 1;

  // Operation codes carried on the input tuser
  localparam logic OpByte  = 1'b0;
  localparam logic OpPixel = 1'b1;

  // Clamp the minimum code size to the legal range 2..8
  function automatic logic [3:0] eff_size(input logic [3:0] m);
    logic [3:0] r;
    r = m;
    if (m < 4'd2) r = 4'd2;
    else if (m > 4'd8) r = 4'd8;
    return r;
  endfunction

  function automatic logic [TableAw-1:0] clear_code(input logic [3:0] m);
    return TableAw'(1) << eff_size(m);
  endfunction

endpackage

// File: sv/gld_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module gld_ram #(
  parameter int unsigned Aw = 12,
  parameter int unsigned Dw = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem [2**Aw];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: sv/gif_lzw_decoder_unit.sv
// GIF variable-length LZW decoder top level: sequencer, bit buffer, dictionary.
// Depends on gld_pkg and gld_ram.
//
// Usage: the slave stream carries one item per transfer. tuser selects the
// operation (0: offer the byte in tdata, 1: pull the next pixel). Every item
// gives exactly one result on the master stream: tdata holds the palette
// index, tuser holds byte_taken, pixel_valid and image_done.
// The minimum code size register is written through cfg_we_i/cfg_wdata_i while
// the block is idle; the user must keep to this, the block itself does not enforce it; a write restarts decoding.
// Sequence: a byte offer is written straight to the output register. A pixel pull
// that finds the string stack non-empty passes through S_POP and S_POPW. A pull
// that decodes a code passes S_DEC, S_RDP, S_RDC and S_GETC, then walks the prefix
// chain in S_WALK and S_WAIT, which reads the dictionary RAM once per character,
// then S_ADD; a code equal to the next free entry walks the previous string and
// first pushes its first character in S_PUSHF. The stack pop then reads the stack RAM.
// One item is in work at a time; tready is low while an item is processed
// or while a result waits in the output register.
// Reset clears all control state; the dictionary and stack RAMs need no
// clearing, entries are only read after being written.
// If the receiver stalls, the result holds in the output register and no new
// item is taken until it is transferred.
module gif_lzw_decoder_unit
  import gld_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,   // min_code_size
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i, // [7:0] data_byte
  input  logic       s_axis_tuser_i, // [0] op
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o, // [7:0] pixel_index
  output logic [2:0] m_axis_tuser_o  // [0] byte_taken [1] pixel_valid [2] image_done
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_RDP, S_RDC, S_GETC, S_PUSHF, S_WALK, S_WAIT, S_ADD,
    S_POP, S_POPW
  } state_e;

  state_e state_q;
  logic [3:0]         min_q;
  logic [23:0]        buf_q;
  logic [4:0]         bc_q;
  logic [3:0]         cw_q;
  logic [CntW-1:0]    nfe_q;
  logic [TableAw-1:0] prev_q, code_q, cur_q;
  logic               pv_q, ended_q, caseb_q;
  logic [CntW-1:0]    sc_q;
  logic [7:0]         fp_q, fc_q;
  logic               out_valid_q;
  logic [7:0]         out_pix_q;
  logic [2:0]         out_user_q;

  logic [TableAw-1:0] clr;
  logic [CntW-1:0]    mask_w;
  logic [TableAw-1:0] code_w;
  logic               add_ok;
  logic [CntW-1:0]    nfe_inc;

  logic               fc_we, dict_we, st_we;
  logic [TableAw-1:0] fc_raddr, st_raddr;
  logic [7:0]         fc_rdata, suf_rdata, st_rdata, st_wdata;
  logic [TableAw-1:0] pre_rdata;

  assign clr     = clear_code(min_q);
  assign mask_w  = (CntW'(1) << cw_q) - CntW'(1);
  assign code_w  = buf_q[TableAw-1:0] & mask_w[TableAw-1:0];
  assign add_ok  = pv_q && (nfe_q < CntW'(MaxCodes));
  assign nfe_inc = nfe_q + CntW'(1);

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tuser_o  = out_user_q;

  // RAM port control
  always_comb begin
    fc_raddr = (state_q == S_RDP) ? prev_q : code_q;
    fc_we    = (state_q == S_ADD) && add_ok;
    dict_we  = fc_we;
    st_raddr = sc_q[TableAw-1:0] - TableAw'(1);
    st_we    = 1'b0;
    st_wdata = fp_q;
    case (state_q)
      S_PUSHF: st_we = 1'b1;
      S_WAIT: begin
        st_we    = 1'b1;
        st_wdata = suf_rdata;
      end
      S_WALK: begin
        if (cur_q < clr) begin
          st_we    = 1'b1;
          st_wdata = cur_q[7:0];
        end
      end
      default: st_we = 1'b0;
    endcase
    // drop pushes beyond the stack depth
    if (sc_q[CntW-1]) st_we = 1'b0;
  end

  gld_ram #(.Aw(TableAw), .Dw(8)) u_first (
    .clk_i, .we_i(fc_we), .waddr_i(nfe_q[TableAw-1:0]), .wdata_i(fp_q),
    .raddr_i(fc_raddr), .rdata_o(fc_rdata)
  );
  gld_ram #(.Aw(TableAw), .Dw(TableAw)) u_prefix (
    .clk_i, .we_i(dict_we), .waddr_i(nfe_q[TableAw-1:0]), .wdata_i(prev_q),
    .raddr_i(cur_q), .rdata_o(pre_rdata)
  );
  gld_ram #(.Aw(TableAw), .Dw(8)) u_suffix (
    .clk_i, .we_i(dict_we), .waddr_i(nfe_q[TableAw-1:0]),
    .wdata_i(caseb_q ? fp_q : fc_q), .raddr_i(cur_q), .rdata_o(suf_rdata)
  );
  gld_ram #(.Aw(TableAw), .Dw(8)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(sc_q[TableAw-1:0]), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      min_q       <= 4'd8;
      buf_q       <= '0;
      bc_q        <= '0;
      cw_q        <= 4'd9;
      nfe_q       <= CntW'(258);
      prev_q      <= '0;
      pv_q        <= 1'b0;
      ended_q     <= 1'b0;
      sc_q        <= '0;
      code_q      <= '0;
      cur_q       <= '0;
      caseb_q     <= 1'b0;
      fp_q        <= '0;
      fc_q        <= '0;
      out_valid_q <= 1'b0;
      out_pix_q   <= '0;
      out_user_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      if (st_we) sc_q <= sc_q + CntW'(1);
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            if (s_axis_tuser_i == OpByte) begin
              out_valid_q <= 1'b1;
              out_pix_q   <= '0;
              if (!ended_q && bc_q <= 5'd16) begin
                buf_q      <= buf_q | (24'(s_axis_tdata_i) << bc_q);
                bc_q       <= bc_q + 5'd8;
                out_user_q <= {ended_q && sc_q == '0, 1'b0, 1'b1};
              end else begin
                out_user_q <= {ended_q && sc_q == '0, 1'b0, 1'b0};
              end
            end else if (sc_q == '0 && !ended_q && bc_q >= 5'(cw_q)) begin
              code_q  <= code_w;
              buf_q   <= buf_q >> cw_q;
              bc_q    <= bc_q - 5'(cw_q);
              state_q <= S_DEC;
            end else begin
              state_q <= S_POP;
            end
          end
        end
        S_DEC: begin
          if (code_q == clr + TableAw'(1)) begin
            ended_q <= 1'b1;
            state_q <= S_POP;
          end else if (code_q == clr) begin
            cw_q    <= eff_size(min_q) + 4'd1;
            nfe_q   <= CntW'(clr) + CntW'(2);
            pv_q    <= 1'b0;
            state_q <= S_POP;
          end else if (CntW'(code_q) < nfe_q) begin
            caseb_q <= 1'b0;
            state_q <= S_RDP;
          end else if (CntW'(code_q) == nfe_q && pv_q) begin
            caseb_q <= 1'b1;
            state_q <= S_RDP;
          end else begin
            state_q <= S_POP;  // undefined code: discard
          end
        end
        S_RDP: state_q <= S_RDC;
        S_RDC: begin
          fp_q    <= (prev_q < clr) ? prev_q[7:0] : fc_rdata;
          state_q <= S_GETC;
        end
        S_GETC: begin
          fc_q    <= (code_q < clr) ? code_q[7:0] : fc_rdata;
          cur_q   <= caseb_q ? prev_q : code_q;
          state_q <= caseb_q ? S_PUSHF : S_WALK;
        end
        S_PUSHF: state_q <= S_WALK;
        S_WALK: begin
          state_q <= (cur_q < clr) ? S_ADD : S_WAIT;
        end
        S_WAIT: begin
          cur_q   <= pre_rdata;
          state_q <= S_WALK;
        end
        S_ADD: begin
          if (add_ok) begin
            nfe_q <= nfe_inc;
            if (nfe_inc == (CntW'(1) << cw_q) && cw_q < 4'(MaxCodeBits)) begin
              cw_q <= cw_q + 4'd1;
            end
          end
          prev_q  <= code_q;
          pv_q    <= 1'b1;
          state_q <= S_POP;
        end
        S_POP: begin
          if (sc_q == '0) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= '0;
            out_user_q  <= {ended_q, 1'b0, 1'b0};
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_POPW;
          end
        end
        S_POPW: begin
          sc_q        <= sc_q - CntW'(1);
          out_valid_q <= 1'b1;
          out_pix_q   <= st_rdata;
          out_user_q  <= {ended_q && sc_q == CntW'(1), 1'b1, 1'b0};
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // register write restarts decoding
      if (cfg_we_i) begin
        min_q   <= cfg_wdata_i;
        buf_q   <= '0;
        bc_q    <= '0;
        cw_q    <= eff_size(cfg_wdata_i) + 4'd1;
        nfe_q   <= CntW'(clear_code(cfg_wdata_i)) + CntW'(2);
        pv_q    <= 1'b0;
        ended_q <= 1'b0;
        sc_q    <= '0;
      end
    end
  end

endmodule

// File: sv/gld_checker.sv
// Port-level checker for the GIF LZW decoder, bound to the top level.
// Depends on gif_lzw_decoder_unit.
module gld_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tuser_o[0] && m_axis_tuser_o[1]))
    else $error("byte taken and pixel valid together");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[1] |-> m_axis_tdata_o == 8'd0)
    else $error("pixel index nonzero without pixel");

  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while result pending");

endmodule

bind gif_lzw_decoder_unit gld_checker u_gld_checker (
  .clk_i, .rst_ni, .s_axis_tready_o, .m_axis_tvalid_o, .m_axis_tready_i,
  .m_axis_tdata_o, .m_axis_tuser_o
);
